[rtl/core/ackdr_pkg.sv]
`default_nettype none
package ackdr_pkg;

   typedef struct packed {
      logic signed [15:0] speed_mm_s;
      logic signed [15:0] steer_angle;
      logic [19:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x_um;
      logic signed [47:0] pos_y_um;
      logic [31:0]        heading;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } rsp_type;

   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 56;
   localparam int DIV_D_W = 32;
   localparam int TRIG_W  = 33;
   localparam int ANG_W   = 34;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032875;
   localparam logic [31:0] STEER_K         = 32'd2734261102;
   localparam logic [16:0] YAW_SCALE       = 17'd87496;
   // ceil(2^45 / 1000): exact x/1000 for x below 2^36
   localparam logic [35:0] POS_RECIP       = 36'd35184372089;
   localparam logic [13:0] WHEELBASE_RESET = 14'd2500;
   localparam logic [13:0] WHEELBASE_MIN   = 14'd100;
   localparam logic signed [47:0] POS_MAX  = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] POS_MIN  = {1'b1, {47{1'b0}}};

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/ackdr_mul.sv]
`default_nettype none
module ackdr_mul import ackdr_pkg::*; (
   input  wire logic               clock,
   input  wire logic [MUL_A_W-1:0] a,
   input  wire logic [MUL_B_W-1:0] b,
   output logic      [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(a) * MUL_P_W'(b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

[rtl/core/ackdr_div.sv]
`default_nettype none
module ackdr_div import ackdr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic      [DIV_N_W-1:0] quotient
);

   localparam logic [5:0] LAST = 6'(DIV_N_W - 1);

   logic [DIV_D_W-1:0] rem_ff, div_ff;
   logic [DIV_N_W-1:0] quot_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff, done_ff;
   logic [DIV_D_W:0]   trial, diff;
   logic               take;

   assign trial = {rem_ff, quot_ff[DIV_N_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign take  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         div_ff  <= divisor;
         quot_ff <= dividend;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quot_ff <= {quot_ff[DIV_N_W-2:0], take};
         cnt_ff  <= cnt_ff + 6'd1;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

[rtl/core/ackdr_cordic.sv]
`default_nettype none
module ackdr_cordic import ackdr_pkg::*; #(
   parameter int STEPS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [31:0]              angle,
   output logic                          done,
   output logic signed [TRIG_W-1:0]      sin_out,
   output logic signed [TRIG_W-1:0]      cos_out
);

   localparam int         NSTEP = (STEPS > 32) ? 32 : STEPS;
   localparam logic [4:0] LAST  = 5'(NSTEP - 1);

   logic signed [TRIG_W-1:0] x_ff, y_ff, dx, dy;
   logic signed [ANG_W-1:0]  z_ff, at;
   logic [4:0]               i_ff;
   logic                     flip_ff, busy_ff, done_ff;
   logic                     flip;
   logic [31:0]              ang_r;

   // fold the left half-plane onto the right one
   assign flip  = angle[31] ^ angle[30];
   assign ang_r = flip ? (angle ^ 32'h80000000) : angle;
   assign dx    = y_ff >>> i_ff;
   assign dy    = x_ff >>> i_ff;
   assign at    = $signed({2'b00, atan_entry(i_ff)});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && i_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= ANG_W'($signed(ang_r));
         i_ff    <= '0;
         flip_ff <= flip;
      end else if (busy_ff) begin
         if (!z_ff[ANG_W-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
         i_ff <= i_ff + 5'd1;
      end
   end

   assign done    = done_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;

endmodule
`default_nettype wire

[rtl/core/ackermann_dead_reckoning_core.sv]
`default_nettype none
// Bicycle-model dead reckoning. Each request beat (speed, steer, elapsed time)
// moves x/y along the old heading, advances the heading by the yaw step and
// returns the new pose with z = sin(h/2), w = cos(h/2). One command is in
// flight at a time. Each command takes three passes of the shared CORDIC
// and two uses of the one-bit-per-cycle 56-bit divider (steer tangent, yaw
// divide by wheelbase); the position scalings are reciprocal multiplies on
// the shared multiplier. The next request is taken while the previous
// response still waits; the one after stalls until that response is taken.
// Wheelbase writes are to be made only while idle; the block itself does
// not enforce this.
module ackermann_dead_reckoning_core import ackdr_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [13:0] csr_wr_data
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_VDT     = 5'd1;
   localparam logic [4:0] S_VDT_W   = 5'd2;
   localparam logic [4:0] S_CRD1    = 5'd3;
   localparam logic [4:0] S_PX_MUL  = 5'd4;
   localparam logic [4:0] S_PX_DIV  = 5'd5;
   localparam logic [4:0] S_PX_RLO  = 5'd6;
   localparam logic [4:0] S_PX_RHI  = 5'd7;
   localparam logic [4:0] S_PX_W    = 5'd8;
   localparam logic [4:0] S_PY_MUL  = 5'd9;
   localparam logic [4:0] S_PY_DIV  = 5'd10;
   localparam logic [4:0] S_PY_RLO  = 5'd11;
   localparam logic [4:0] S_PY_RHI  = 5'd12;
   localparam logic [4:0] S_PY_W    = 5'd13;
   localparam logic [4:0] S_AM_MUL  = 5'd14;
   localparam logic [4:0] S_AM_W    = 5'd15;
   localparam logic [4:0] S_CRD2    = 5'd16;
   localparam logic [4:0] S_TAN_DIV = 5'd17;
   localparam logic [4:0] S_TAN_W   = 5'd18;
   localparam logic [4:0] S_Q_MUL   = 5'd19;
   localparam logic [4:0] S_Q_DIV   = 5'd20;
   localparam logic [4:0] S_Q_W     = 5'd21;
   localparam logic [4:0] S_R_LO    = 5'd22;
   localparam logic [4:0] S_R_HI    = 5'd23;
   localparam logic [4:0] S_R_ADD   = 5'd24;
   localparam logic [4:0] S_CRD3    = 5'd25;
   localparam logic [4:0] S_OUT     = 5'd26;

   logic [4:0]  state_ff, state_in;
   logic [13:0] wheelbase_ff;
   logic [15:0] vm_ff;
   logic        vneg_ff;
   logic [14:0] stm_ff;
   logic        stneg_ff;
   logic [19:0] dt_ff;
   logic [35:0] vdt_ff;
   logic [35:0] m_ff;
   logic signed [TRIG_W-1:0] sn_ff, cs_ff;
   logic [16:0] t16_ff;
   logic [45:0] q_ff;
   logic [MUL_P_W-1:0] acc_ff;
   logic signed [47:0] x_ff, y_ff;
   logic [31:0] heading_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;
   logic               div_start, div_done;
   logic [DIV_N_W-1:0] div_n, quot;
   logic [DIV_D_W-1:0] div_d;
   logic               crd_start, crd_done;
   logic [31:0]        crd_ang;
   logic signed [TRIG_W-1:0] crd_sin, crd_cos;

   logic signed [15:0] st_sat;
   logic signed [TRIG_W-1:0] tc, ts, sn_abs;
   logic [24:0]  tc_mag, ts_mag;
   logic [13:0]  wb_eff;
   logic [46:0]  am_sum;
   logic [31:0]  steer_ang;
   logic [63:0]  r_sum;
   logic [31:0]  dh, heading_nx;
   logic [71:0]  pos_prod;
   logic [26:0]  pos_quot;
   logic signed [48:0] pos_delta, pos_sum;
   logic signed [47:0] pos_sat;
   logic signed [47:0] pos_base;
   logic         pos_neg;
   logic signed [17:0] qz_r, qw_r;
   logic signed [15:0] qz_s, qw_s;
   logic         accept;

   ackdr_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   ackdr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (quot)
   );

   ackdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (crd_start),
      .angle   (crd_ang),
      .done    (crd_done),
      .sin_out (crd_sin),
      .cos_out (crd_cos)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      if (req_data.steer_angle > 16'sd16384) begin
         st_sat = 16'sd16384;
      end else if (req_data.steer_angle < -16'sd16384) begin
         st_sat = -16'sd16384;
      end else begin
         st_sat = req_data.steer_angle;
      end
   end

   // trig rounded to Q24
   assign tc     = (cs_ff + TRIG_W'(32)) >>> 6;
   assign ts     = (sn_ff + TRIG_W'(32)) >>> 6;
   assign tc_mag = tc[TRIG_W-1] ? 25'(-tc) : tc[24:0];
   assign ts_mag = ts[TRIG_W-1] ? 25'(-ts) : ts[24:0];
   assign sn_abs = sn_ff[TRIG_W-1] ? -sn_ff : sn_ff;
   assign wb_eff = (wheelbase_ff < WHEELBASE_MIN) ? WHEELBASE_MIN : wheelbase_ff;

   assign am_sum    = prod[46:0] + 47'd32768;
   assign steer_ang = stneg_ff ? -32'(am_sum[46:16]) : 32'(am_sum[46:16]);

   assign r_sum      = 64'(acc_ff) + (64'(prod) << 22) + 64'h800000;
   assign dh         = (vneg_ff ^ sn_ff[TRIG_W-1]) ? -r_sum[55:24] : r_sum[55:24];
   assign heading_nx = heading_ff + dh;

   always_comb begin
      mul_a = 36'(vdt_ff);
      mul_b = '0;
      case (state_ff)
         S_VDT: begin
            mul_a = 36'(vm_ff);
            mul_b = 25'(dt_ff);
         end
         S_PX_MUL: mul_b = tc_mag;
         S_PY_MUL: mul_b = ts_mag;
         S_PX_RLO, S_PY_RLO: begin
            mul_a = POS_RECIP;
            mul_b = m_ff[24:0];
         end
         S_PX_RHI, S_PY_RHI: begin
            mul_a = POS_RECIP;
            mul_b = 25'(m_ff[35:25]);
         end
         S_AM_MUL: begin
            mul_a = 36'(STEER_K);
            mul_b = 25'(stm_ff);
         end
         S_Q_MUL:  mul_b = 25'(t16_ff);
         S_R_LO: begin
            mul_a = 36'(q_ff[21:0]);
            mul_b = 25'(YAW_SCALE);
         end
         S_R_HI: begin
            mul_a = 36'(q_ff[45:22]);
            mul_b = 25'(YAW_SCALE);
         end
         default: ;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_n     = '0;
      div_d     = '0;
      case (state_ff)
         S_TAN_DIV: begin
            div_start = 1'b1;
            div_n     = 56'({sn_abs, 16'h0000});
            div_d     = (cs_ff < TRIG_W'(1)) ? 32'd1 : cs_ff[31:0];
         end
         S_Q_DIV: begin
            div_start = 1'b1;
            div_n     = prod[DIV_N_W-1:0];
            div_d     = 32'(wb_eff);
         end
         default: ;
      endcase
   end

   always_comb begin
      crd_start = 1'b0;
      crd_ang   = {heading_ff[30:0], 1'b0};
      case (state_ff)
         S_VDT_W: crd_start = 1'b1;
         S_AM_W: begin
            crd_start = 1'b1;
            crd_ang   = steer_ang;
         end
         S_R_ADD: begin
            crd_start = 1'b1;
            crd_ang   = heading_nx;
         end
         default: ;
      endcase
   end

   // divide by 1000 (m is already scaled down by 2^24): low and high partial products of m * recip, >> 45
   assign pos_prod = 72'(acc_ff) + (72'(prod) << 25);
   assign pos_quot = pos_prod[71:45];

   // signed step and saturating accumulate, shared by x and y
   assign pos_neg   = vneg_ff ^ ((state_ff == S_PX_W) ? tc[TRIG_W-1] : ts[TRIG_W-1]);
   assign pos_base  = (state_ff == S_PX_W) ? x_ff : y_ff;
   assign pos_delta = pos_neg ? -$signed(49'(pos_quot)) : $signed(49'(pos_quot));
   assign pos_sum   = {pos_base[47], pos_base} + pos_delta;
   assign pos_sat   = (pos_sum[48] != pos_sum[47]) ? (pos_sum[48] ? POS_MIN : POS_MAX)
                                                    : pos_sum[47:0];

   assign qz_r = 18'((crd_sin + TRIG_W'(16384)) >>> 15);
   assign qw_r = 18'((crd_cos + TRIG_W'(16384)) >>> 15);
   assign qz_s = (qz_r > 18'sd32767) ? 16'sd32767 :
                 (qz_r < -18'sd32768) ? -16'sd32768 : qz_r[15:0];
   assign qw_s = (qw_r > 18'sd32767) ? 16'sd32767 :
                 (qw_r < -18'sd32768) ? -16'sd32768 : qw_r[15:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (accept) state_in = S_VDT;
         S_VDT:     state_in = S_VDT_W;
         S_VDT_W:   state_in = S_CRD1;
         S_CRD1:    if (crd_done) state_in = S_PX_MUL;
         S_PX_MUL:  state_in = S_PX_DIV;
         S_PX_DIV:  state_in = S_PX_RLO;
         S_PX_RLO:  state_in = S_PX_RHI;
         S_PX_RHI:  state_in = S_PX_W;
         S_PX_W:    state_in = S_PY_MUL;
         S_PY_MUL:  state_in = S_PY_DIV;
         S_PY_DIV:  state_in = S_PY_RLO;
         S_PY_RLO:  state_in = S_PY_RHI;
         S_PY_RHI:  state_in = S_PY_W;
         S_PY_W:    state_in = S_AM_MUL;
         S_AM_MUL:  state_in = S_AM_W;
         S_AM_W:    state_in = S_CRD2;
         S_CRD2:    if (crd_done) state_in = S_TAN_DIV;
         S_TAN_DIV: state_in = S_TAN_W;
         S_TAN_W:   if (div_done) state_in = S_Q_MUL;
         S_Q_MUL:   state_in = S_Q_DIV;
         S_Q_DIV:   state_in = S_Q_W;
         S_Q_W:     if (div_done) state_in = S_R_LO;
         S_R_LO:    state_in = S_R_HI;
         S_R_HI:    state_in = S_R_ADD;
         S_R_ADD:   state_in = S_CRD3;
         S_CRD3:    if (crd_done) state_in = S_OUT;
         S_OUT:     if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wheelbase_ff <= WHEELBASE_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) wheelbase_ff <= csr_wr_data;
         if (state_ff == S_PX_W) x_ff <= pos_sat;
         if (state_ff == S_PY_W) y_ff <= pos_sat;
         if (state_ff == S_R_ADD) heading_ff <= heading_nx;
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vm_ff    <= req_data.speed_mm_s[15] ? 16'(-req_data.speed_mm_s)
                                             : 16'(req_data.speed_mm_s);
         vneg_ff  <= req_data.speed_mm_s[15];
         stm_ff   <= st_sat[15] ? 15'(-st_sat) : st_sat[14:0];
         stneg_ff <= st_sat[15];
         dt_ff    <= req_data.elapsed_us;
      end
      if (state_ff == S_VDT_W) vdt_ff <= prod[35:0];
      if ((state_ff == S_CRD1 || state_ff == S_CRD2) && crd_done) begin
         sn_ff <= crd_sin;
         cs_ff <= crd_cos;
      end
      if (state_ff inside {S_PX_DIV, S_PY_DIV}) begin
         m_ff <= 36'(37'(prod[MUL_P_W-1:24]) + 37'd500);
      end
      if (state_ff == S_TAN_W && div_done) t16_ff <= quot[16:0];
      if (state_ff == S_Q_W && div_done) q_ff <= quot[45:0];
      if (state_ff inside {S_PX_RHI, S_PY_RHI, S_R_HI}) acc_ff <= prod;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.pos_x_um <= x_ff;
         rsp_ff.pos_y_um <= y_ff;
         rsp_ff.heading  <= heading_ff;
         rsp_ff.quat_z   <= qz_s;
         rsp_ff.quat_w   <= qw_s;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
